/* sv/mswf_pkg.sv */
package mswf_pkg;

    localparam int SAMPLE_W = 16;
    localparam int SUM_W    = 21;
    localparam int CFG_W    = 6;

    // Descriptor fields sized for the largest supported window (64)
    localparam int DLEN_W   = 7;
    localparam int DIDX_W   = 6;

    localparam int QDEPTH   = 2;
    localparam int QPTR_W   = 1;
    localparam int QCNT_W   = 2;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [SUM_W-1:0]    sum_t;

    // One emission job handed from the front to the back
    typedef struct packed {
        sum_t              sum;
        logic [DIDX_W-1:0] start;
        logic [DLEN_W-1:0] len;
        logic              too_short;
    } desc_t;

endpackage

/* sv/mswf_front.sv */
module mswf_front
    import mswf_pkg::*;
#(
    parameter int MAX_WINDOW = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 window_len_we,
    input  logic [CFG_W-1:0]     window_len_wdata,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  sample_t              sample,
    input  logic                 is_last,
    output logic                 push,
    output desc_t                push_desc,
    output sample_t              best_window [MAX_WINDOW]
);

    localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int LEN_W = $clog2(MAX_WINDOW + 1);
    localparam int CMP_W = LEN_W + 1;

    logic [CFG_W-1:0] window_len_reg;
    logic [IDX_W-1:0] ptr_reg;
    logic [IDX_W-1:0] ptr_next;
    logic [LEN_W-1:0] seen_reg;
    logic [LEN_W-1:0] seen_next;
    sum_t             run_sum_reg;
    sum_t             run_sum_next;
    logic             best_valid_reg;
    logic             best_valid_next;
    sum_t             best_sum_reg;
    logic [IDX_W-1:0] best_start_reg;
    sample_t          ring_reg [MAX_WINDOW];
    sample_t          best_window_reg [MAX_WINDOW];

    logic [LEN_W-1:0] len;
    logic [IDX_W-1:0] ptr;
    logic [CMP_W-1:0] ptr_inc;
    logic             full;
    sum_t             oldest;
    logic             better;
    logic             accept;
    sum_t             best_sum_after;
    logic [IDX_W-1:0] best_start_after;

    // Effective length: zero means one, saturate at the store depth
    always_comb
    begin
        if (window_len_reg == '0)
            len = LEN_W'(1);
        else if (int'(window_len_reg) > MAX_WINDOW)
            len = LEN_W'(MAX_WINDOW);
        else
            len = LEN_W'(window_len_reg);
    end

    assign accept = in_valid && in_ready;

    always_comb
    begin
        ptr          = (CMP_W'(ptr_reg) >= CMP_W'(len)) ? '0 : ptr_reg;
        full         = (seen_reg >= len);
        oldest       = full ? SUM_W'(ring_reg[ptr]) : '0;
        run_sum_next = run_sum_reg - oldest + SUM_W'(sample);
        seen_next    = full ? seen_reg : seen_reg + LEN_W'(1);
        ptr_inc      = CMP_W'(ptr) + CMP_W'(1);
        ptr_next     = (ptr_inc == CMP_W'(len)) ? '0 : ptr_inc[IDX_W-1:0];
        better       = (seen_next >= len) &&
                       (!best_valid_reg || (run_sum_next < best_sum_reg));
        best_valid_next  = best_valid_reg || better;
        best_sum_after   = better ? run_sum_next : best_sum_reg;
        best_start_after = better ? ptr_next : best_start_reg;
    end

    assign push                = accept && is_last;
    assign push_desc.sum       = best_valid_next ? best_sum_after : '0;
    assign push_desc.start     = DIDX_W'(best_start_after);
    assign push_desc.len       = DLEN_W'(len);
    assign push_desc.too_short = !best_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_len_reg <= CFG_W'(1);
            ptr_reg        <= '0;
            seen_reg       <= '0;
            run_sum_reg    <= '0;
            best_valid_reg <= 1'b0;
        end
        else if (window_len_we)
        begin
            // New length: restart the array in progress
            window_len_reg <= window_len_wdata;
            ptr_reg        <= '0;
            seen_reg       <= '0;
            run_sum_reg    <= '0;
            best_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (is_last)
            begin
                ptr_reg        <= '0;
                seen_reg       <= '0;
                run_sum_reg    <= '0;
                best_valid_reg <= 1'b0;
            end
            else
            begin
                ptr_reg        <= ptr_next;
                seen_reg       <= seen_next;
                run_sum_reg    <= run_sum_next;
                best_valid_reg <= best_valid_next;
            end
        end
    end

    // On first full window or strictly lower sum, snapshot ring plus sample
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ring_reg[ptr] <= sample;
            if (better)
            begin
                best_sum_reg   <= run_sum_next;
                best_start_reg <= ptr_next;
                for (int j = 0; j < MAX_WINDOW; j++)
                begin
                    best_window_reg[j] <= (IDX_W'(j) == ptr) ? sample : ring_reg[j];
                end
            end
        end
    end

    assign best_window = best_window_reg;

endmodule

/* sv/mswf_queue.sv */
module mswf_queue
    import mswf_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  desc_t push_desc,
    input  logic  pop,
    output logic  empty,
    output desc_t head
);

    desc_t             q_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign empty = (count_reg == '0);
    assign head  = q_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + QCNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_ptr_reg] <= push_desc;
    end

endmodule

/* sv/mswf_back.sv */
module mswf_back
    import mswf_pkg::*;
#(
    parameter int MAX_WINDOW = 32
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    q_empty,
    input  desc_t   head,
    output logic    pop,
    input  sample_t best_window [MAX_WINDOW],
    output logic    out_valid,
    input  logic    out_ready,
    output sample_t element,
    output sum_t    window_sum,
    output logic    end_of_run,
    output logic    too_short
);

    localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int LEN_W = $clog2(MAX_WINDOW + 1);
    localparam int CMP_W = LEN_W + 1;

    logic             busy_reg;
    logic [LEN_W-1:0] k_reg;
    sample_t          win_reg [MAX_WINDOW];
    sum_t             run_sum_reg;
    logic [LEN_W-1:0] run_len_reg;
    logic [IDX_W-1:0] run_start_reg;
    logic             run_short_reg;

    logic             out_valid_reg;
    sample_t          element_reg;
    sum_t             window_sum_reg;
    logic             end_of_run_reg;
    logic             too_short_reg;

    logic             load;
    logic             last_word;
    logic [CMP_W-1:0] idx_sum;
    logic [CMP_W-1:0] idx_wrap;
    logic [IDX_W-1:0] rd_idx;

    assign pop  = !busy_reg && !q_empty;
    assign load = busy_reg && (!out_valid_reg || out_ready);

    always_comb
    begin
        idx_sum   = CMP_W'(run_start_reg) + CMP_W'(k_reg);
        idx_wrap  = (idx_sum >= CMP_W'(run_len_reg)) ? idx_sum - CMP_W'(run_len_reg) : idx_sum;
        rd_idx    = idx_wrap[IDX_W-1:0];
        last_word = run_short_reg || ((CMP_W'(k_reg) + CMP_W'(1)) == CMP_W'(run_len_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                busy_reg <= 1'b1;
                k_reg    <= '0;
            end
            else if (load)
            begin
                k_reg <= k_reg + LEN_W'(1);
                if (last_word)
                    busy_reg <= 1'b0;
            end

            if (load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            win_reg       <= best_window;
            run_sum_reg   <= head.sum;
            run_len_reg   <= LEN_W'(head.len);
            run_start_reg <= IDX_W'(head.start);
            run_short_reg <= head.too_short;
        end
        if (load)
        begin
            element_reg    <= run_short_reg ? '0 : win_reg[rd_idx];
            window_sum_reg <= run_short_reg ? '0 : run_sum_reg;
            end_of_run_reg <= last_word;
            too_short_reg  <= run_short_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign element    = element_reg;
    assign window_sum = window_sum_reg;
    assign end_of_run = end_of_run_reg;
    assign too_short  = too_short_reg;

endmodule

/* sv/min_sum_window_finder_top.sv */
// Minimum-sum sliding window finder.
// Input channel (in_valid/in_ready, sample, is_last): one signed sample per
// word; is_last marks the final sample of an array. Output channel
// (out_valid/out_ready, element, window_sum, end_of_run, too_short): on the
// last sample the earliest window with the smallest sum goes out one element
// per word, in array order, end_of_run set on its final word. An array shorter
// than the window yields a single word with too_short and end_of_run set.
// Configuration: window_len_we/window_len_wdata write the window length
// (0 acts as 1, lengths above MAX_WINDOW saturate); a write restarts the array.
// Throughput: one sample per cycle inside an array. After a last sample the
// input stalls until the emitter has taken the job off the job queue, which it
// does once it is no longer busy with an earlier run. The emitter then sends
// the effective window length in words (a single word for a too-short array),
// one per cycle when out_ready stays high. Reset clears the stream state, the
// job queue and the output valid flag and sets the window length to 1. A stall
// on out_ready holds the output word.
module min_sum_window_finder_top
    import mswf_pkg::*;
#(
    parameter int MAX_WINDOW = 32
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             window_len_we,
    input  logic [CFG_W-1:0] window_len_wdata,
    input  logic             in_valid,
    output logic             in_ready,
    input  sample_t          sample,
    input  logic             is_last,
    output logic             out_valid,
    input  logic             out_ready,
    output sample_t          element,
    output sum_t             window_sum,
    output logic             end_of_run,
    output logic             too_short
);

    logic    push;
    desc_t   push_desc;
    logic    pop;
    logic    q_empty;
    desc_t   head;
    sample_t best_window [MAX_WINDOW];

    // Hold the input while a job waits: the emitter copies the best window
    // from the front when it pops, so the front must not overwrite it first.
    assign in_ready = q_empty;

    // Front: ring, running sum, best-window tracking
    mswf_front #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .window_len_we    (window_len_we),
        .window_len_wdata (window_len_wdata),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .sample           (sample),
        .is_last          (is_last),
        .push             (push),
        .push_desc        (push_desc),
        .best_window      (best_window)
    );

    // Job queue between front and emitter
    mswf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .pop       (pop),
        .empty     (q_empty),
        .head      (head)
    );

    // Back: emit the stored window word by word
    mswf_back #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .head        (head),
        .pop         (pop),
        .best_window (best_window),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .element     (element),
        .window_sum  (window_sum),
        .end_of_run  (end_of_run),
        .too_short   (too_short)
    );

endmodule
